### design/pts_pkg.sv
// Shared types and constants of the message timeout and cycle scheduler.
package pts_pkg;

   // Widths of the entry and group fields follow from the table and group sizes.
   localparam int NUM_ENTRIES = 16;
   localparam int NUM_GROUPS  = 8;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int GIDX_W      = $clog2(NUM_GROUPS);
   localparam int GCNT_W      = GIDX_W + 1;
   localparam int LEN_W       = 7;
   localparam int TIME_W      = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PDUS_IN_USE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS_IN_USE = 1'b1;

   // Command codes of an input word.
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_RX_IND  = 3'd3,
      CMD_TX_CONF = 3'd4,
      CMD_LOAD    = 3'd5
   } cmd_code_type;

   // Entry directions.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_RX   = 2'd1,
      DIR_TX   = 2'd2
   } dir_type;

   // Event codes of a result word.
   typedef enum logic [2:0] {
      EV_RX_OK      = 3'd0,
      EV_RX_TIMEOUT = 3'd1,
      EV_SEND       = 3'd2,
      EV_REFUSED    = 3'd3,
      EV_TX_DONE    = 3'd4,
      EV_TX_ERROR   = 3'd5
   } event_type;

   // Input word.
   typedef struct packed {
      logic [2:0]        command;
      logic [IDX_W-1:0]  pdu_index;
      logic [GIDX_W-1:0] group_index;
      logic [LEN_W-1:0]  received_length;
      logic [15:0]       tx_accept_mask;
      logic              tx_ok;
      logic [1:0]        entry_direction;
      logic [7:0]        entry_groups;
      logic [TIME_W-1:0] entry_first_time;
      logic [TIME_W-1:0] entry_period;
      logic [LEN_W-1:0]  entry_length;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [2:0]       event_res;
      logic [IDX_W-1:0] event_entry;
      logic             last;
   } rsp_type;

   // Classified command passed from the front end to the engine.
   typedef struct packed {
      cmd_code_type      op;
      logic [IDX_W-1:0]  pdu_index;
      logic [GIDX_W-1:0] group_index;
      logic [LEN_W-1:0]  received_length;
      logic [15:0]       tx_accept_mask;
      logic              tx_ok;
      dir_type           entry_direction;
      logic [7:0]        entry_groups;
      logic [TIME_W-1:0] entry_first_time;
      logic [TIME_W-1:0] entry_period;
      logic [LEN_W-1:0]  entry_length;
   } cmd_type;

endpackage

### design/pts_front.sv
// Front end: configuration registers, command classification and filtering.
module pts_front
   import pts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               push_data,
   output logic [CNT_W-1:0]      entry_count
);

   logic [CNT_W-1:0]  pdus_in_use_ff;
   logic [GCNT_W-1:0] groups_in_use_ff;
   logic [GCNT_W-1:0] group_count;
   logic              pdu_ok;
   logic              grp_ok;
   logic              keep;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pdus_in_use_ff   <= '0;
         groups_in_use_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PDUS_IN_USE:   pdus_in_use_ff   <= csr_wdata[CNT_W-1:0];
            CSR_GROUPS_IN_USE: groups_in_use_ff <= csr_wdata[GCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Counts above the table or group size act as the size.
   assign entry_count = (pdus_in_use_ff > CNT_W'(NUM_ENTRIES)) ?
                        CNT_W'(NUM_ENTRIES) : pdus_in_use_ff;
   assign group_count = (groups_in_use_ff > GCNT_W'(NUM_GROUPS)) ?
                        GCNT_W'(NUM_GROUPS) : groups_in_use_ff;

   assign pdu_ok = {1'b0, req_data.pdu_index} < entry_count;
   assign grp_ok = {1'b0, req_data.group_index} < group_count;

   // Commands that can have no effect are dropped here.
   always_comb begin
      case (req_data.command)
         CMD_TICK:                         keep = 1'b1;
         CMD_START, CMD_STOP:              keep = grp_ok;
         CMD_RX_IND, CMD_TX_CONF, CMD_LOAD: keep = pdu_ok;
         default:                          keep = 1'b0;
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready && keep;

   // Build the queued command; direction code three is stored as none.
   always_comb begin
      push_data.op               = cmd_code_type'(req_data.command);
      push_data.pdu_index        = req_data.pdu_index;
      push_data.group_index      = req_data.group_index;
      push_data.received_length  = req_data.received_length;
      push_data.tx_accept_mask   = req_data.tx_accept_mask;
      push_data.tx_ok            = req_data.tx_ok;
      push_data.entry_groups     = req_data.entry_groups;
      push_data.entry_first_time = req_data.entry_first_time;
      push_data.entry_period     = req_data.entry_period;
      push_data.entry_length     = req_data.entry_length;
      case (req_data.entry_direction)
         2'd1:    push_data.entry_direction = DIR_RX;
         2'd2:    push_data.entry_direction = DIR_TX;
         default: push_data.entry_direction = DIR_NONE;
      endcase
   end

endmodule

### design/pts_queue.sv
// Short command queue between the front end and the engine.
module pts_queue
   import pts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Storage is written without reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (!push && do_pop) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

### design/pts_engine.sv
// Engine: entry table, group state, table walks and result output.
module pts_engine
   import pts_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] entry_count,
   input  logic             head_valid,
   input  cmd_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_RX_WALK    = 5'b00010,
      ST_TX_WALK    = 5'b00100,
      ST_START_WALK = 5'b01000,
      ST_FLUSH      = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       walk_ff, walk_in;
   cmd_type                cmd_ff, cmd_in;
   logic [NUM_GROUPS-1:0]  group_active_ff, group_active_in;

   logic [TIMER_BITS-1:0]  timer_ff [NUM_ENTRIES];
   dir_type                dir_ff   [NUM_ENTRIES];
   logic [7:0]             gmask_ff [NUM_ENTRIES];
   logic [TIMER_BITS-1:0]  first_ff [NUM_ENTRIES];
   logic [TIMER_BITS-1:0]  cycle_ff [NUM_ENTRIES];
   logic [LEN_W-1:0]       bytes_ff [NUM_ENTRIES];

   logic                   pend_valid_ff, pend_valid_in;
   event_type              pend_res_ff, pend_res_in;
   logic [IDX_W-1:0]       pend_entry_ff, pend_entry_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]       rd_idx;
   logic [TIMER_BITS-1:0]  rd_timer;
   dir_type                rd_dir;
   logic [7:0]             rd_gmask;
   logic [TIMER_BITS-1:0]  rd_first;
   logic [TIMER_BITS-1:0]  rd_cycle;
   logic [LEN_W-1:0]       rd_bytes;
   logic                   rd_enabled;
   logic                   rd_running;
   logic                   rd_expires;
   logic                   walk_last;
   logic                   out_free;
   logic                   emit_block;
   logic                   timer_we;
   logic [TIMER_BITS-1:0]  timer_wd;
   logic                   load_we;
   logic                   emit;
   event_type              emit_res;
   logic                   flush_out;
   logic                   out_load;
   logic                   out_last;
   logic [NUM_GROUPS-1:0]  head_gbit;
   logic [NUM_GROUPS-1:0]  cmd_gbit;

   // Single table read port: the addressed entry when idle, else the walk position.
   assign rd_idx     = (state_ff == ST_IDLE) ? head.pdu_index : walk_ff;
   assign rd_timer   = timer_ff[rd_idx];
   assign rd_dir     = dir_ff[rd_idx];
   assign rd_gmask   = gmask_ff[rd_idx];
   assign rd_first   = first_ff[rd_idx];
   assign rd_cycle   = cycle_ff[rd_idx];
   assign rd_bytes   = bytes_ff[rd_idx];
   assign rd_enabled = |(group_active_ff & rd_gmask);
   assign rd_running = rd_enabled && (rd_timer != '0);
   assign rd_expires = rd_timer == TIMER_BITS'(1);

   assign walk_last  = (CNT_W'(walk_ff) + CNT_W'(1)) == entry_count;
   assign head_gbit  = NUM_GROUPS'(1) << head.group_index;
   assign cmd_gbit   = NUM_GROUPS'(1) << cmd_ff.group_index;

   // The output register can take a word this cycle.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // A new event needs the pending word moved out first.
   assign emit_block = pend_valid_ff && !out_free;

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      walk_in         = walk_ff;
      cmd_in          = cmd_ff;
      group_active_in = group_active_ff;
      pop             = 1'b0;
      timer_we        = 1'b0;
      timer_wd        = '0;
      load_we         = 1'b0;
      emit            = 1'b0;
      emit_res        = EV_RX_OK;
      flush_out       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cmd_in = head;
               case (head.op)
                  CMD_TICK: begin
                     if (entry_count != '0) begin
                        walk_in  = '0;
                        state_in = ST_RX_WALK;
                     end
                  end
                  CMD_START: begin
                     group_active_in = group_active_ff | head_gbit;
                     if (entry_count != '0) begin
                        walk_in  = '0;
                        state_in = ST_START_WALK;
                     end
                  end
                  CMD_STOP: begin
                     group_active_in = group_active_ff & ~head_gbit;
                  end
                  CMD_RX_IND: begin
                     if (rd_dir == DIR_RX && rd_enabled &&
                         rd_bytes <= head.received_length) begin
                        timer_we = 1'b1;
                        timer_wd = rd_cycle;
                        emit     = 1'b1;
                        emit_res = EV_RX_OK;
                     end
                     state_in = ST_FLUSH;
                  end
                  CMD_TX_CONF: begin
                     if (rd_dir == DIR_TX && rd_enabled) begin
                        emit     = 1'b1;
                        emit_res = head.tx_ok ? EV_TX_DONE : EV_TX_ERROR;
                     end
                     state_in = ST_FLUSH;
                  end
                  CMD_LOAD: begin
                     load_we = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_RX_WALK: begin
            // Receive pass: count down and report a deadline miss at zero.
            if (!(rd_dir == DIR_RX && rd_running && rd_expires && emit_block)) begin
               if (rd_dir == DIR_RX && rd_running) begin
                  timer_we = 1'b1;
                  timer_wd = rd_timer - TIMER_BITS'(1);
                  emit     = rd_expires;
                  emit_res = EV_RX_TIMEOUT;
               end
               if (walk_last) begin
                  walk_in  = '0;
                  state_in = ST_TX_WALK;
               end else begin
                  walk_in = walk_ff + IDX_W'(1);
               end
            end
         end
         ST_TX_WALK: begin
            // Transmit pass: at zero send, then reload or retry next tick.
            if (!(rd_dir == DIR_TX && rd_running && rd_expires && emit_block)) begin
               if (rd_dir == DIR_TX && rd_running) begin
                  timer_we = 1'b1;
                  if (rd_expires) begin
                     emit = 1'b1;
                     if (cmd_ff.tx_accept_mask[walk_ff]) begin
                        timer_wd = rd_cycle;
                        emit_res = EV_SEND;
                     end else begin
                        timer_wd = TIMER_BITS'(1);
                        emit_res = EV_REFUSED;
                     end
                  end else begin
                     timer_wd = rd_timer - TIMER_BITS'(1);
                  end
               end
               if (walk_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  walk_in = walk_ff + IDX_W'(1);
               end
            end
         end
         ST_START_WALK: begin
            // Load the first time, or the period, into each receive or transmit member of the group.
            if (|(rd_gmask & cmd_gbit) && (rd_dir == DIR_RX || rd_dir == DIR_TX)) begin
               timer_we = 1'b1;
               timer_wd = (rd_first != '0) ? rd_first : rd_cycle;
            end
            if (walk_last) begin
               state_in = ST_IDLE;
            end else begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            // Send the held word out marked as the last one.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush_out = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // One event is held back until the next one, or the end, tells whether it is last.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_res_in   = pend_res_ff;
      pend_entry_in = pend_entry_ff;
      out_load      = 1'b0;
      out_last      = 1'b0;
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_res_in   = emit_res;
         pend_entry_in = rd_idx;
         out_load      = pend_valid_ff;
      end else if (flush_out) begin
         pend_valid_in = 1'b0;
         out_load      = 1'b1;
         out_last      = 1'b1;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_data_in.event_res   = pend_res_ff;
         rsp_data_in.event_entry = pend_entry_ff;
         rsp_data_in.last        = out_last;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         walk_ff         <= '0;
         group_active_ff <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         walk_ff         <= walk_in;
         group_active_ff <= group_active_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pend_res_ff   <= pend_res_in;
      pend_entry_ff <= pend_entry_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Entry table; all entries start cleared.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            timer_ff[i] <= '0;
            dir_ff[i]   <= DIR_NONE;
            gmask_ff[i] <= '0;
            first_ff[i] <= '0;
            cycle_ff[i] <= '0;
            bytes_ff[i] <= '0;
         end
      end else if (load_we) begin
         timer_ff[rd_idx] <= '0;
         dir_ff[rd_idx]   <= head.entry_direction;
         gmask_ff[rd_idx] <= head.entry_groups;
         first_ff[rd_idx] <= TIMER_BITS'(head.entry_first_time);
         cycle_ff[rd_idx] <= TIMER_BITS'(head.entry_period);
         bytes_ff[rd_idx] <= head.entry_length;
      end else if (timer_we) begin
         timer_ff[rd_idx] <= timer_wd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/pdu_timeout_and_cycle_scheduler_unit.sv
// Top level of the message receive-deadline and cyclic-transmit scheduler.
//
// The block keeps a table of 16 message entries and 8 groups. A front end takes
// one word per cycle, unless the queue is full, into a two-deep command queue,
// dropping words that address an entry or group beyond the configured counts;
// an engine then carries each command out against the table, which has one read
// port and is walked one entry per cycle while no result is held up. A tick is
// a receive pass and a transmit pass over the table, then the final word; a
// group start is one pass. Results leave through an output register, so the
// engine keeps walking while a result waits to be taken, until a new event
// finds the held word blocked; the final result of each input word carries last.
// Timers are TIMER_BITS wide; loaded times are truncated to that width. The
// user must write configuration only while idle; the block does not enforce it.
module pdu_timeout_and_cycle_scheduler_unit
   import pts_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   logic             queue_full;
   logic             push;
   cmd_type          push_data;
   logic             pop;
   logic             head_valid;
   cmd_type          head;
   logic [CNT_W-1:0] entry_count;

   // Configuration and command classification.
   pts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data),
      .entry_count (entry_count)
   );

   // Decoupling queue.
   pts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .head_valid(head_valid),
      .head      (head)
   );

   // Table engine and result output.
   pts_engine #(
      .TIMER_BITS(TIMER_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .entry_count(entry_count),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### dv/pdu_timeout_and_cycle_scheduler_unit_test.sv
// Self-checking testbench of the message timeout and cycle scheduler with its event predictor.
`timescale 1ns / 100ps

module pdu_timeout_and_cycle_scheduler_unit_test;
   import pts_pkg::*;

   // Command and direction codes that the block has no name for.
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam logic [1:0] DIR_SPARE    = 2'd3;

   // A tick over a full table is a receive pass and a transmit pass. Once the last event is
   // out, the engine and each queue slot can still hold a silent tick; allow some margin on top.
   localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 1) * (2 * NUM_ENTRIES + 2) + 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int LONG_HOLD     = 400;

   // Holds a copy of the table and predicts the event words each input word causes.
   class pdu_event_scoreboard;
      logic [CSR_DATA_W-1:0] pdus_in_use;
      logic [3:0]            groups_in_use;
      logic [NUM_GROUPS-1:0] group_active;
      logic [TIME_W-1:0]     timer [NUM_ENTRIES];
      dir_type               dir [NUM_ENTRIES];
      logic [7:0]            group_mask [NUM_ENTRIES];
      logic [TIME_W-1:0]     first_time [NUM_ENTRIES];
      logic [TIME_W-1:0]     period [NUM_ENTRIES];
      logic [LEN_W-1:0]      bytes [NUM_ENTRIES];
      rsp_type               pending_events [$];
      int unsigned           mismatch_count;
      int unsigned           checked_count;

      function new();
         pdus_in_use = '0;
         groups_in_use = '0;
         group_active = '0;
         mismatch_count = 0;
         checked_count = 0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            timer[i] = '0;
            dir[i] = DIR_NONE;
            group_mask[i] = '0;
            first_time[i] = '0;
            period[i] = '0;
            bytes[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_PDUS_IN_USE) begin
            pdus_in_use = value;
         end else begin
            groups_in_use = value[3:0];
         end
      endfunction

      function bit enabled(int i);
         return (group_active & group_mask[i]) != '0;
      endfunction

      function rsp_type make_event(event_type ev, int idx);
         rsp_type r;
         r.event_res = ev;
         r.event_entry = IDX_W'(idx);
         r.last = 1'b0;
         return r;
      endfunction

      // Update the table copy for one accepted word and queue the events it causes.
      function void predict_events(req_type w);
         int unsigned           cnt;
         int unsigned           gcnt;
         int unsigned           pi;
         logic [NUM_GROUPS-1:0] gbit;
         rsp_type               fresh [$];
         cnt = (pdus_in_use > NUM_ENTRIES) ? NUM_ENTRIES : pdus_in_use;
         gcnt = (groups_in_use > NUM_GROUPS) ? NUM_GROUPS : groups_in_use;
         pi = w.pdu_index;
         gbit = NUM_GROUPS'(1) << w.group_index;
         case (w.command)
            CMD_TICK: begin
               // Receive pass first, then the transmit pass.
               for (int i = 0; i < cnt; i++) begin
                  if (dir[i] == DIR_RX && enabled(i) && timer[i] != '0) begin
                     timer[i] = timer[i] - 1'b1;
                     if (timer[i] == '0) fresh.push_back(make_event(EV_RX_TIMEOUT, i));
                  end
               end
               for (int i = 0; i < cnt; i++) begin
                  if (dir[i] == DIR_TX && enabled(i) && timer[i] != '0) begin
                     timer[i] = timer[i] - 1'b1;
                     if (timer[i] == '0) begin
                        if (w.tx_accept_mask[i]) begin
                           timer[i] = period[i];
                           fresh.push_back(make_event(EV_SEND, i));
                        end else begin
                           timer[i] = TIME_W'(1);
                           fresh.push_back(make_event(EV_REFUSED, i));
                        end
                     end
                  end
               end
            end
            CMD_START: begin
               if (w.group_index < gcnt) begin
                  group_active = group_active | gbit;
                  for (int i = 0; i < cnt; i++) begin
                     if ((group_mask[i] & gbit) != '0 && (dir[i] == DIR_RX || dir[i] == DIR_TX))
                        timer[i] = (first_time[i] != '0) ? first_time[i] : period[i];
                  end
               end
            end
            CMD_STOP: begin
               if (w.group_index < gcnt) group_active = group_active & ~gbit;
            end
            CMD_RX_IND: begin
               if (pi < cnt && dir[pi] == DIR_RX && enabled(pi) && bytes[pi] <= w.received_length) begin
                  timer[pi] = period[pi];
                  fresh.push_back(make_event(EV_RX_OK, pi));
               end
            end
            CMD_TX_CONF: begin
               if (pi < cnt && dir[pi] == DIR_TX && enabled(pi))
                  fresh.push_back(make_event(w.tx_ok ? EV_TX_DONE : EV_TX_ERROR, pi));
            end
            CMD_LOAD: begin
               if (pi < cnt) begin
                  // The spare direction code is stored as no direction.
                  if (w.entry_direction == DIR_RX || w.entry_direction == DIR_TX) begin
                     dir[pi] = dir_type'(w.entry_direction);
                  end else begin
                     dir[pi] = DIR_NONE;
                  end
                  group_mask[pi] = w.entry_groups;
                  first_time[pi] = w.entry_first_time;
                  period[pi] = w.entry_period;
                  bytes[pi] = w.entry_length;
                  timer[pi] = '0;
               end
            end
            default: begin
            end
         endcase
         // The final event of the word carries last.
         for (int k = 0; k < fresh.size(); k++) begin
            rsp_type r;
            r = fresh[k];
            r.last = (k == fresh.size() - 1);
            pending_events.push_back(r);
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      // Compare one accepted event word with the oldest prediction.
      task check_event(rsp_type got);
         rsp_type want;
         checked_count++;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected word event %0d entry %0d last %0d",
                                      got.event_res, got.event_entry, got.last));
            return;
         end
         want = pending_events.pop_front();
         if (got.event_res !== want.event_res)
            report_mismatch($sformatf("event %0d, predicted %0d", got.event_res, want.event_res));
         if (got.event_entry !== want.event_entry)
            report_mismatch($sformatf("entry %0d, predicted %0d", got.event_entry, want.event_entry));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, predicted %0d", got.last, want.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   bit                    steady_phase = 1'b0;
   int unsigned           cycle_count = 0;

   pdu_event_scoreboard events_sb;

   pdu_timeout_and_cycle_scheduler_unit DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Random input word, biased toward small times so that timers expire often.
   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) w.command = CMD_TICK;
      else if (pick < 55) w.command = CMD_START;
      else if (pick < 60) w.command = CMD_STOP;
      else if (pick < 72) w.command = CMD_RX_IND;
      else if (pick < 82) w.command = CMD_TX_CONF;
      else if (pick < 97) w.command = CMD_LOAD;
      else if (pick < 99) w.command = CMD_SPARE_LO;
      else w.command = CMD_SPARE_HI;
      w.pdu_index = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
      w.group_index = GIDX_W'($urandom_range(0, NUM_GROUPS - 1));
      w.received_length = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                                      : LEN_W'($urandom_range(0, 64));
      case ($urandom_range(0, 3))
         0: w.tx_accept_mask = '1;
         1: w.tx_accept_mask = '0;
         default: w.tx_accept_mask = 16'($urandom);
      endcase
      w.tx_ok = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 4) w.entry_direction = DIR_RX;
      else if (pick < 8) w.entry_direction = DIR_TX;
      else w.entry_direction = 2'($urandom);
      w.entry_groups = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : 8'(1 << $urandom_range(0, NUM_GROUPS - 1));
      w.entry_first_time = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                       : TIME_W'($urandom_range(0, 6));
      pick = $urandom_range(0, 19);
      if (pick == 0) w.entry_period = '0;
      else if (pick < 3) w.entry_period = TIME_W'($urandom);
      else w.entry_period = TIME_W'($urandom_range(1, 10));
      w.entry_length = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                                   : LEN_W'($urandom_range(0, 64));
      return w;
   endfunction

   // Offer one word, with an occasional gap first, and note it once accepted.
   task automatic send_word(input req_type w);
      if (!steady_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      events_sb.predict_events(w);
   endtask

   task automatic send_cmd(input logic [2:0] cmd, input int pdu, input int grp,
                           input int rlen, input logic [15:0] accept, input bit ok);
      req_type w;
      w = random_word();
      w.command = cmd;
      w.pdu_index = IDX_W'(pdu);
      w.group_index = GIDX_W'(grp);
      w.received_length = LEN_W'(rlen);
      w.tx_accept_mask = accept;
      w.tx_ok = ok;
      send_word(w);
   endtask

   task automatic send_load(input int pdu, input logic [1:0] dir, input logic [7:0] groups,
                            input logic [TIME_W-1:0] first, input logic [TIME_W-1:0] per,
                            input int len);
      req_type w;
      w = random_word();
      w.command = CMD_LOAD;
      w.pdu_index = IDX_W'(pdu);
      w.entry_direction = dir;
      w.entry_groups = groups;
      w.entry_first_time = first;
      w.entry_period = per;
      w.entry_length = LEN_W'(len);
      send_word(w);
   endtask

   // Stop offering, wait for every predicted event, then let any word still queued finish.
   task automatic drain_and_wait();
      req_valid <= 1'b0;
      while (events_sb.pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] pdus,
                             input logic [CSR_DATA_W-1:0] groups);
      csr_write_en <= 1'b1;
      csr_index <= CSR_PDUS_IN_USE;
      csr_wdata <= pdus;
      @(posedge clock);
      csr_index <= CSR_GROUPS_IN_USE;
      csr_wdata <= groups;
      @(posedge clock);
      csr_write_en <= 1'b0;
      events_sb.write_reg(CSR_PDUS_IN_USE, pdus);
      events_sb.write_reg(CSR_GROUPS_IN_USE, groups);
   endtask

   // One setting of the registers, opened by a few loads and group starts.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] pdus,
                            input logic [CSR_DATA_W-1:0] groups, input int n_words,
                            input bit steady);
      req_type w;
      drain_and_wait();
      set_config(pdus, groups);
      steady_phase = steady;
      for (int k = 0; k < n_words; k++) begin
         w = random_word();
         if (k < 6) w.command = CMD_LOAD;
         else if (k < 8) w.command = CMD_START;
         send_word(w);
      end
   endtask

   // Result side: random stalls, one long hold to back the block up, none at the end.
   initial begin : result_side
      int unsigned stall_left;
      bit          long_hold_done;
      stall_left = 0;
      long_hold_done = 1'b0;
      rsp_ready = 1'b0;
      wait (events_sb != null && reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) events_sb.check_event(rsp_data);
         if (!long_hold_done && events_sb.checked_count >= 40) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed words, then random phases over several settings.
   initial begin : stimulus
      events_sb = new();
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_PDUS_IN_USE;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // With no entries in use everything is ignored.
      send_cmd(CMD_TICK, 0, 0, 0, '1, 1'b1);
      send_load(0, DIR_RX, 8'h01, 16'd1, 16'd1, 0);
      drain_and_wait();
      set_config(CSR_DATA_W'(NUM_ENTRIES), CSR_DATA_W'(NUM_GROUPS));

      // Table setup, including the extremes of times and lengths and the spare direction.
      send_load(0, DIR_RX, 8'h01, 16'd2, 16'd3, 64);
      send_load(1, DIR_TX, 8'h01, 16'd0, 16'd2, 0);
      send_load(15, DIR_TX, 8'h80, 16'hFFFF, 16'hFFFF, 127);
      send_load(2, DIR_SPARE, 8'hFF, 16'd1, 16'd1, 5);
      send_load(3, DIR_RX, 8'h02, 16'd0, 16'd1, 10);
      send_cmd(CMD_START, 0, 0, 0, '0, 1'b0);
      send_cmd(CMD_START, 0, 7, 0, '0, 1'b0);
      send_cmd(CMD_START, 0, 1, 0, '0, 1'b0);
      // Timeouts, a refused send that retries, then an accepted send.
      send_cmd(CMD_TICK, 0, 0, 0, '0, 1'b0);
      send_cmd(CMD_TICK, 0, 0, 0, '0, 1'b0);
      send_cmd(CMD_TICK, 0, 0, 0, '1, 1'b0);
      // Indications: long enough, too short, and on a transmit entry.
      send_cmd(CMD_RX_IND, 0, 0, 64, '0, 1'b0);
      send_cmd(CMD_RX_IND, 3, 0, 9, '0, 1'b0);
      send_cmd(CMD_RX_IND, 1, 0, 64, '0, 1'b0);
      // Confirmations: success, failure, and on a receive entry.
      send_cmd(CMD_TX_CONF, 1, 0, 0, '0, 1'b1);
      send_cmd(CMD_TX_CONF, 1, 0, 0, '0, 1'b0);
      send_cmd(CMD_TX_CONF, 0, 0, 0, '0, 1'b1);
      // A stopped group disables its entries.
      send_cmd(CMD_STOP, 0, 0, 0, '0, 1'b0);
      send_cmd(CMD_TICK, 0, 0, 0, '1, 1'b1);
      send_cmd(CMD_TX_CONF, 1, 0, 0, '0, 1'b1);
      // Unknown commands are ignored.
      send_cmd(CMD_SPARE_LO, 0, 0, 0, '1, 1'b1);
      send_cmd(CMD_SPARE_HI, 15, 7, 127, '1, 1'b1);

      // Random phases: in-range, minimal, over-range, no groups, a masked group count, steady in-range.
      run_phase(5'd16, 5'd8, 60, 1'b0);
      run_phase(5'd1, 5'd1, 50, 1'b0);
      run_phase(5'd31, 5'd15, 60, 1'b0);
      run_phase(5'd16, 5'd0, 50, 1'b0);
      run_phase(5'd7, 5'd24, 50, 1'b0);
      run_phase(5'd16, 5'd8, 60, 1'b1);

      drain_and_wait();
      if (events_sb.mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
